// ===== src/cir_pkg.sv =====
// Shared types, widths and helpers for the contact impulse response pipeline.
package cir_pkg;

  localparam int IN_DATA_W  = 288;
  localparam int OUT_DATA_W = 256;
  localparam int M_W        = 36;   // rounded closing speed
  localparam int BIG_W      = 54;   // restitution term times closing speed
  localparam int HALF_W     = 27;   // split point of the wide product
  localparam int PP_W       = 58;   // one partial product
  localparam int NUM_W      = 85;   // dividend width
  localparam int DEN_W      = 48;   // divisor width (mass sum in Q16.16 << 16)
  localparam int QB         = 39;   // quotient bits
  localparam int DIV_LAT    = QB + 2;

  localparam logic [2:0] KIND_BOTH     = 3'd1;
  localparam logic [2:0] KIND_A_STATIC = 3'd2;
  localparam logic [2:0] KIND_B_STATIC = 3'd3;

  typedef enum logic [1:0] {
    OUT_APPLIED    = 2'd0,
    OUT_PASS       = 2'd1,
    OUT_SEPARATING = 2'd2,
    OUT_ZERO_MASS  = 2'd3
  } outcome_t;

  // Per-contact data that rides alongside the arithmetic
  typedef struct packed {
    logic [2:0]          kind;
    outcome_t            outcome;
    logic signed [15:0]  nx;
    logic signed [15:0]  ny;
    logic signed [31:0]  vax;
    logic signed [31:0]  vay;
    logic signed [31:0]  vbx;
    logic signed [31:0]  vby;
    logic signed [33:0]  px;
    logic signed [33:0]  py;
  } side_t;

  // Clip to signed 32 bits; bit 32 flags a clip
  function automatic logic [32:0] sat32(input logic signed [47:0] v);
    logic [32:0] r;
    if (v > 48'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -48'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== src/cir_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounded quotient.
module cir_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [cir_pkg::NUM_W-1:0]  num,
  input  logic [cir_pkg::DEN_W-1:0]  den,
  output logic [cir_pkg::QB-1:0]     quo
);

  localparam int QB = cir_pkg::QB;
  localparam int DW = cir_pkg::DEN_W;
  localparam int NW = cir_pkg::NUM_W;

  logic [DW-1:0] rem  [0:QB];
  logic [DW-1:0] dd   [0:QB];
  logic [QB-1:0] nlo  [0:QB];
  logic [QB-1:0] qq   [0:QB];
  logic          up;

  // Load the high dividend bits as the first partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(num[NW-1:QB]);
      nlo[0] <= num[QB-1:0];
      dd[0]  <= den;
      qq[0]  <= '0;
    end
  end

  // One compare and subtract per stage
  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    assign t    = {rem[k-1], nlo[k-1][QB-1]};
    assign diff = t - {1'b0, dd[k-1]};
    assign ge   = (t >= {1'b0, dd[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
        nlo[k] <= {nlo[k-1][QB-2:0], 1'b0};
        dd[k]  <= dd[k-1];
        qq[k]  <= {qq[k-1][QB-2:0], ge};
      end
    end
  end

  // Round half up on the final remainder
  assign up = ({rem[QB], 1'b0} >= {1'b0, dd[QB]});

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= qq[QB] + QB'(up);
    end
  end

endmodule

// ===== src/contact_impulse_response.sv =====
// Top level: pipelined 2D contact position correction and impulse response.
//
//  port group | dir | tdata                         | tuser
//  s_*        | in  | contact normal, depth, bodies | contact_kind
//  m_*        | out | moves and new velocities      | outcome, saturated
//
// One contact enters per cycle unless the output stalls. A result passes 50 register
// stages: seven arithmetic stages, the 41-stage divider (load, 39 quotient bits,
// rounding), the normal scaling stage and the output register. The first of them
// loads at the edge that takes the beat.
// rst clears the valid bits only; the pipeline then drains empty.
// All stages advance together: a stalled result beat holds the whole pipeline,
// and s_tready follows m_tready whenever the output register is full.
module contact_impulse_response (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // normal_x, normal_y, depth, vel_a_x, vel_a_y, vel_b_x, vel_b_y,
  // inv_mass_a, inv_mass_b, restitution_a, restitution_b, zero pad
  input  logic [cir_pkg::IN_DATA_W-1:0]     s_tdata,
  // contact_kind
  input  logic [2:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // move_a_x, move_a_y, move_b_x, move_b_y,
  // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
  output logic [cir_pkg::OUT_DATA_W-1:0]    m_tdata,
  // outcome, saturated
  output logic [2:0]                        m_tuser
);

  localparam int DL = cir_pkg::DIV_LAT;

  logic en;
  logic v1, v2, v3, v4, v5, v6, v7, v8;
  logic [DL-1:0] vd;

  cir_pkg::side_t side1, side2, side3, side4, side5, side6, side7, side8;
  cir_pkg::side_t side3_next, side4_next;
  cir_pkg::side_t sd [0:DL-1];

  logic [30:0] depth1, ia1, ib1, ia2, ib2, ia3, ib3, ia4, ib4, ia5, ib5;
  logic [16:0] ra1, rb1;
  logic signed [32:0] dx2, dy2;
  logic signed [47:0] pxp2, pyp2;
  logic [17:0] e2, e3, e4;
  logic [31:0] s2, s3, s4, s5, s6;
  logic signed [48:0] prx3, pry3;
  logic [cir_pkg::M_W-1:0] m4;
  logic [cir_pkg::BIG_W-1:0] big5;
  logic [cir_pkg::PP_W-1:0] pal6, pah6, pbl6, pbh6;
  logic [cir_pkg::NUM_W-1:0] na7, nb7;
  logic [cir_pkg::DEN_W-1:0] d7;
  logic [cir_pkg::QB-1:0] ka, kb;
  logic signed [55:0] kax8, kay8, kbx8, kby8;

  // stage combinational values
  logic signed [47:0] tx3, ty3;
  logic signed [33:0] px3, py3;
  logic signed [49:0] dot4;
  logic [50:0] nd4;
  logic        act4;
  cir_pkg::outcome_t oc4;
  logic signed [47:0] fin [0:7];
  logic [32:0] sat [0:7];
  logic        act9, app9;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
      vd <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5; v7 <= v6;
      vd <= {vd[DL-2:0], v7};
      v8 <= vd[DL-1];
      m_tvalid <= v8;
    end
  end

  // Round the position correction: half depth when both bodies move
  always_comb begin
    tx3 = pxp2 + ((side2.kind == cir_pkg::KIND_BOTH) ? 48'sd16384 : 48'sd8192);
    ty3 = pyp2 + ((side2.kind == cir_pkg::KIND_BOTH) ? 48'sd16384 : 48'sd8192);
    px3 = (side2.kind == cir_pkg::KIND_BOTH) ? {tx3[47], tx3[47:15]} : tx3[47:14];
    py3 = (side2.kind == cir_pkg::KIND_BOTH) ? {ty3[47], ty3[47:15]} : ty3[47:14];
    side3_next    = side2;
    side3_next.px = px3;
    side3_next.py = py3;
  end

  // Classify the contact and round the closing speed
  always_comb begin
    dot4 = 50'(prx3) + 50'(pry3);
    nd4  = 51'(-$signed({dot4[49], dot4})) + 51'd8192;
    act4 = (side3.kind == cir_pkg::KIND_BOTH) || (side3.kind == cir_pkg::KIND_A_STATIC) ||
           (side3.kind == cir_pkg::KIND_B_STATIC);
    if (!act4) begin
      oc4 = cir_pkg::OUT_PASS;
    end else if (dot4 > 50'sd0) begin
      oc4 = cir_pkg::OUT_SEPARATING;
    end else if (s3 == 32'd0) begin
      oc4 = cir_pkg::OUT_ZERO_MASS;
    end else begin
      oc4 = cir_pkg::OUT_APPLIED;
    end
    side4_next         = side3;
    side4_next.outcome = oc4;
  end

  // Arithmetic stages ahead of the divider
  always_ff @(posedge clk) begin
    if (en) begin
      side1.kind    <= s_tuser;
      side1.outcome <= cir_pkg::OUT_PASS;
      side1.nx      <= s_tdata[15:0];
      side1.ny      <= s_tdata[31:16];
      depth1        <= s_tdata[62:32];
      side1.vax     <= s_tdata[94:63];
      side1.vay     <= s_tdata[126:95];
      side1.vbx     <= s_tdata[158:127];
      side1.vby     <= s_tdata[190:159];
      ia1           <= s_tdata[221:191];
      ib1           <= s_tdata[252:222];
      ra1           <= s_tdata[269:253];
      rb1           <= s_tdata[286:270];
      side1.px      <= '0;
      side1.py      <= '0;

      side2 <= side1;
      dx2   <= 33'(side1.vbx) - 33'(side1.vax);
      dy2   <= 33'(side1.vby) - 33'(side1.vay);
      pxp2  <= 48'(side1.nx) * $signed({17'd0, depth1});
      pyp2  <= 48'(side1.ny) * $signed({17'd0, depth1});
      e2    <= 18'd65536 + 18'((ra1 < rb1) ? ra1 : rb1);
      s2    <= {1'b0, ia1} + {1'b0, ib1};
      ia2   <= ia1;
      ib2   <= ib1;

      side3 <= side3_next;
      prx3  <= 49'(side2.nx) * 49'(dx2);
      pry3  <= 49'(side2.ny) * 49'(dy2);
      e3 <= e2; s3 <= s2; ia3 <= ia2; ib3 <= ib2;

      side4 <= side4_next;
      m4 <= nd4[cir_pkg::M_W+13:14];
      e4 <= e3; s4 <= s3; ia4 <= ia3; ib4 <= ib3;

      side5 <= side4;
      big5  <= cir_pkg::BIG_W'(e4) * cir_pkg::BIG_W'(m4);
      s5 <= s4; ia5 <= ia4; ib5 <= ib4;

      side6 <= side5;
      pal6 <= cir_pkg::PP_W'(big5[cir_pkg::HALF_W-1:0]) * cir_pkg::PP_W'(ia5);
      pah6 <= cir_pkg::PP_W'(big5[cir_pkg::BIG_W-1:cir_pkg::HALF_W]) * cir_pkg::PP_W'(ia5);
      pbl6 <= cir_pkg::PP_W'(big5[cir_pkg::HALF_W-1:0]) * cir_pkg::PP_W'(ib5);
      pbh6 <= cir_pkg::PP_W'(big5[cir_pkg::BIG_W-1:cir_pkg::HALF_W]) * cir_pkg::PP_W'(ib5);
      s6 <= s5;

      side7 <= side6;
      na7 <= cir_pkg::NUM_W'(pal6) + {pah6, {cir_pkg::HALF_W{1'b0}}};
      nb7 <= cir_pkg::NUM_W'(pbl6) + {pbh6, {cir_pkg::HALF_W{1'b0}}};
      d7  <= {s6, 16'd0};
    end
  end

  cir_div u_div_a (.clk(clk), .en(en), .num(na7), .den(d7), .quo(ka));
  cir_div u_div_b (.clk(clk), .en(en), .num(nb7), .den(d7), .quo(kb));

  // Delay the side data to meet the quotients, then scale the normal
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side7;
      for (int i = 1; i < DL; i++) begin
        sd[i] <= sd[i-1];
      end
      side8 <= sd[DL-1];
      kax8 <= 56'(sd[DL-1].nx) * $signed({1'b0, ka});
      kay8 <= 56'(sd[DL-1].ny) * $signed({1'b0, ka});
      kbx8 <= 56'(sd[DL-1].nx) * $signed({1'b0, kb});
      kby8 <= 56'(sd[DL-1].ny) * $signed({1'b0, kb});
    end
  end

  // Pick moves and velocities, then clip
  always_comb begin
    act9 = (side8.outcome != cir_pkg::OUT_PASS);
    app9 = (side8.outcome == cir_pkg::OUT_APPLIED);
    fin[0] = (act9 && side8.kind != cir_pkg::KIND_A_STATIC) ? -48'(side8.px) : 48'sd0;
    fin[1] = (act9 && side8.kind != cir_pkg::KIND_A_STATIC) ? -48'(side8.py) : 48'sd0;
    fin[2] = (act9 && side8.kind != cir_pkg::KIND_B_STATIC) ? 48'(side8.px) : 48'sd0;
    fin[3] = (act9 && side8.kind != cir_pkg::KIND_B_STATIC) ? 48'(side8.py) : 48'sd0;
    fin[4] = 48'(side8.vax);
    fin[5] = 48'(side8.vay);
    fin[6] = 48'(side8.vbx);
    fin[7] = 48'(side8.vby);
    if (app9) begin
      fin[4] = 48'(side8.vax) - 48'((kax8 + 56'sd8192) >>> 14);
      fin[5] = 48'(side8.vay) - 48'((kay8 + 56'sd8192) >>> 14);
      fin[6] = 48'(side8.vbx) + 48'((kbx8 + 56'sd8192) >>> 14);
      fin[7] = 48'(side8.vby) + 48'((kby8 + 56'sd8192) >>> 14);
    end
    for (int i = 0; i < 8; i++) begin
      sat[i] = cir_pkg::sat32(fin[i]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        m_tdata[i*32 +: 32] <= sat[i][31:0];
      end
      m_tuser <= {sat[0][32] | sat[1][32] | sat[2][32] | sat[3][32] |
                  sat[4][32] | sat[5][32] | sat[6][32] | sat[7][32],
                  side8.outcome};
    end
  end

  // A passed-through pair moves nothing and clips nothing
  a_pass_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] == cir_pkg::OUT_PASS) |->
      (m_tdata[127:0] == 128'd0 && !m_tuser[2]))
    else $error("pass-through result carries a move or clip");

  // Input side takes a beat only when the pipeline advances
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready does not follow pipeline advance");

  // A stalled pipeline keeps the valid bits of its first and scaling stages
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> (v1 == $past(v1) && v8 == $past(v8)))
    else $error("stage valid moved during stall");

  // Output valid follows the last stage one advance later
  a_follow: assert property (@(posedge clk) disable iff (rst)
    (en && v8) |=> m_tvalid)
    else $error("result beat lost at output");

endmodule
